FILE: rtl/nprox_pkg.sv
// ----------------------------------------------------------------------------
// nprox_pkg
// Shared constants, codes and the item record for the proximal map pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package nprox_pkg;

  localparam int MAX_LEN_DEF   = 65536;
  localparam int FRAC_BITS_DEF = 16;

  // log2 fraction bits and ln(2) at that scale
  localparam int              LN_FRAC = 28;
  localparam logic [27:0]     LN2_Q   = 28'd186065279;

  localparam logic [30:0]     THETA_RESET = 31'd65536;

  typedef enum logic [1:0] {
    MODE_CAPPED = 2'd0,
    MODE_LOGSUM = 2'd1,
    MODE_TNN    = 2'd2,
    MODE_PASS   = 2'd3
  } mode_t;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_LAMBDA = 2'd1;
  localparam logic [1:0] REG_THETA  = 2'd2;

  // record carried alongside the arithmetic units
  typedef struct packed {
    logic               ls;
    logic signed [33:0] xs;
    logic signed [31:0] d;
    logic signed [63:0] dd;
    logic               zero;
    logic               skip;
    logic signed [33:0] x;
    logic signed [33:0] diff;
  } item_t;

  function automatic logic [5:0] msb_pos(input logic [33:0] a);
    logic [5:0] k;
    k = '0;
    for (int i = 0; i < 34; i++) begin
      if (a[i]) begin
        k = 6'(i);
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/nprox_if.sv
// ----------------------------------------------------------------------------
// nprox_if
// Channel interfaces: element input, result output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface nprox_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [15:0] element_index;
  modport source (output valid, value, element_index, input ready);
  modport sink   (input valid, value, element_index, output ready);
endinterface

interface nprox_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic               saturated;
  modport source (output valid, result, saturated, input ready);
  modport sink   (input valid, result, saturated, output ready);
endinterface

interface nprox_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/nonconvex_proximal_map_core.sv
// ----------------------------------------------------------------------------
// nonconvex_proximal_map_core
// Element-wise nonconvex proximal map (capped L1, log sum, truncated nuclear, pass-through).
// ----------------------------------------------------------------------------
// Usage:
//   elem carries one signed Q16.16 element and its index per word; res returns
//   one saturated Q16.16 result and a clip flag per element, in order.
//   cfg writes mode (0), lambda (1) and theta (2); it is ready whenever rst is
//   low. The user must write cfg only while no element is in flight; the block does not enforce it.
// Throughput: one element per cycle while the skid stage is empty.
// Depth: set mostly by the 32-stage square root and the 30-stage log2 unit
//   (msb search, normalize, 28 squarings).
// Stall: an output register plus a one-word skid stage; when the skid holds a
//   word the whole pipeline freezes and elem.ready drops, nothing is lost.
// Reset: all valid bits clear, elem and cfg are not ready, mode = capped L1,
//   lambda = 0, theta = 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module nonconvex_proximal_map_core #(
  parameter int MAX_LEN   = nprox_pkg::MAX_LEN_DEF,
  parameter int FRAC_BITS = nprox_pkg::FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  nprox_in_if.sink    elem,
  nprox_out_if.source res,
  nprox_cfg_if.sink   cfg
);

  localparam int PM_SHIFT = nprox_pkg::LN_FRAC - 1 - FRAC_BITS;

  nprox_pkg::mode_t mode;
  logic [30:0]      lambda;
  logic [30:0]      theta;

  logic en;
  logic skid_v;

  assign en         = !skid_v;
  assign elem.ready = en && !rst;
  assign cfg.ready  = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= nprox_pkg::MODE_CAPPED;
      lambda <= '0;
      theta  <= nprox_pkg::THETA_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        nprox_pkg::REG_MODE:   mode   <= nprox_pkg::mode_t'(cfg.data[1:0]);
        nprox_pkg::REG_LAMBDA: lambda <= cfg.data[30:0];
        nprox_pkg::REG_THETA:  theta  <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  // stage 1: simple modes and |d + theta|
  logic signed [31:0] d_in;
  logic signed [33:0] sum1, d_lam;
  logic signed [34:0] two_d, lim;
  logic        [31:0] mag1;
  logic signed [33:0] xs1;
  logic        [30:0] keep;
  logic               idx_ok;

  always_comb begin
    d_in   = elem.value;
    sum1   = $signed({{2{d_in[31]}}, d_in}) + $signed({3'b0, theta});
    mag1   = sum1[33] ? 32'(-sum1) : sum1[31:0];
    d_lam  = $signed({{2{d_in[31]}}, d_in}) - $signed({3'b0, lambda});
    two_d  = $signed({{2{d_in[31]}}, d_in, 1'b0});
    lim    = $signed({3'b0, theta, 1'b0}) + $signed({4'b0, lambda});
    keep   = theta >> FRAC_BITS;
    idx_ok = ({15'd0, elem.element_index} >= keep) &&
             (32'(elem.element_index) < 32'(MAX_LEN));
    unique case (mode)
      nprox_pkg::MODE_CAPPED: begin
        if (two_d < lim) begin
          xs1 = d_lam[33] ? '0 : d_lam;
        end else begin
          xs1 = 34'(d_in);
        end
      end
      nprox_pkg::MODE_TNN: xs1 = idx_ok ? d_lam : 34'(d_in);
      nprox_pkg::MODE_LOGSUM,
      nprox_pkg::MODE_PASS: xs1 = 34'(d_in);
    endcase
  end

  logic              s1_v;
  nprox_pkg::item_t  s1, s1_next;
  logic [31:0]       s1_mag;

  always_comb begin
    s1_next    = '0;
    s1_next.ls = (mode == nprox_pkg::MODE_LOGSUM);
    s1_next.xs = xs1;
    s1_next.d  = d_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= elem.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1      <= s1_next;
      s1_mag  <= mag1;
    end
  end

  // stage 2: squares
  logic              s2_v;
  nprox_pkg::item_t  s2, s2_next;
  logic [63:0]       s2_sq, s2_four;

  always_comb begin
    s2_next    = s1;
    s2_next.dd = 64'(s1.d) * 64'(s1.d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2      <= s2_next;
      s2_sq   <= {32'd0, s1_mag} * {32'd0, s1_mag};
      s2_four <= {33'd0, lambda} << (FRAC_BITS + 2);
    end
  end

  // stage 3: discriminant
  logic              s3_v;
  nprox_pkg::item_t  s3, s3_next;
  logic [63:0]       s3_rad;

  always_comb begin
    s3_next      = s2;
    s3_next.zero = s2_sq <= s2_four;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3      <= s3_next;
      s3_rad  <= s2_sq - s2_four;
    end
  end

  logic              q_v;
  logic [31:0]       q_root;
  nprox_pkg::item_t  q;

  nprox_isqrt #(.side_t(nprox_pkg::item_t)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (s3_v),
    .in_rad   (s3_rad),
    .in_side  (s3),
    .out_v    (q_v),
    .out_root (q_root),
    .out_side (q)
  );

  // stage A: root x = floor((d - theta + s) / 2)
  logic signed [34:0] tot;
  assign tot = $signed({{3{q.d[31]}}, q.d}) - $signed({4'b0, theta}) +
               $signed({3'b0, q_root});

  logic              sa_v;
  nprox_pkg::item_t  sa, sa_next;

  always_comb begin
    sa_next   = q;
    sa_next.x = tot[34:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_v <= 1'b0;
    end else if (en) begin
      sa_v <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa   <= sa_next;
    end
  end

  // stage B: log argument and distance to d
  logic signed [34:0] num;
  assign num = $signed({sa.x[33], sa.x}) + $signed({4'b0, theta});

  logic              sb_v;
  nprox_pkg::item_t  sb, sb_next;
  logic [33:0]       sb_num;

  always_comb begin
    sb_next      = sa;
    sb_next.skip = (theta == '0) || (num <= 0);
    sb_next.diff = sa.x - $signed({{2{sa.d[31]}}, sa.d});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_v <= 1'b0;
    end else if (en) begin
      sb_v <= sa_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb      <= sb_next;
      sb_num  <= num[33:0];
    end
  end

  logic              l_v;
  logic [33:0]       l_a, l_b;
  nprox_pkg::item_t  li;

  nprox_log2 #(.side_t(nprox_pkg::item_t)) u_log (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (sb_v),
    .in_a     (sb_num),
    .in_b     ({3'b0, theta}),
    .in_side  (sb),
    .out_v    (l_v),
    .out_la   (l_a),
    .out_lb   (l_b),
    .out_side (li)
  );

  // stage E: log difference, (x - d)^2
  logic signed [67:0] sq2_full;
  assign sq2_full = li.diff * li.diff;

  logic               se_v;
  nprox_pkg::item_t   se;
  logic [33:0]        se_dl;
  logic               se_neg;
  logic signed [63:0] se_sq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      se_v <= 1'b0;
    end else if (en) begin
      se_v <= l_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      se     <= li;
      se_neg <= l_a < l_b;
      se_dl  <= (l_a < l_b) ? (l_b - l_a) : (l_a - l_b);
      se_sq2 <= sq2_full[63:0];
    end
  end

  // stage F: ln via ln2 scale, left side
  logic [61:0] lnp;
  assign lnp = {28'd0, se_dl} * {34'd0, nprox_pkg::LN2_Q};

  logic               sf_v;
  nprox_pkg::item_t   sf;
  logic [33:0]        sf_lnm;
  logic               sf_neg;
  logic signed [64:0] sf_lhs;

  always_ff @(posedge clk) begin
    if (rst) begin
      sf_v <= 1'b0;
    end else if (en) begin
      sf_v <= se_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf     <= se;
      sf_neg <= se_neg;
      sf_lnm <= lnp[61:28];
      sf_lhs <= $signed({se.dd[63], se.dd}) - $signed({se_sq2[63], se_sq2});
    end
  end

  // stage G: 2 * lambda * ln(q)
  logic [64:0] pprod;
  logic [63:0] pm;
  assign pprod = {34'd0, lambda} * {31'd0, sf_lnm};
  assign pm    = 64'(pprod >> PM_SHIFT);

  logic               sg_v;
  nprox_pkg::item_t   sg;
  logic signed [63:0] sg_rhs;
  logic signed [64:0] sg_lhs;

  always_ff @(posedge clk) begin
    if (rst) begin
      sg_v <= 1'b0;
    end else if (en) begin
      sg_v <= sf_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg     <= sf;
      sg_lhs <= sf_lhs;
      sg_rhs <= sf_neg ? -$signed(pm) : $signed(pm);
    end
  end

  // stage H: pick result and clip
  logic signed [65:0] lhs_x, rhs_x;
  logic signed [33:0] xf;
  logic signed [31:0] p_res;
  logic               p_sat;

  always_comb begin
    lhs_x = 66'(sg_lhs);
    rhs_x = 66'(sg_rhs);
    if (!sg.ls) begin
      xf = sg.xs;
    end else if (sg.zero) begin
      xf = '0;
    end else if (sg.skip) begin
      xf = sg.x;
    end else begin
      xf = (lhs_x < rhs_x) ? '0 : sg.x;
    end
    if (xf > 34'sh07FFFFFFF) begin
      p_res = 32'sh7FFFFFFF;
      p_sat = 1'b1;
    end else if (xf < -34'sh080000000) begin
      p_res = 32'sh80000000;
      p_sat = 1'b1;
    end else begin
      p_res = xf[31:0];
      p_sat = 1'b0;
    end
  end

  // output register and skid word
  logic               o_v;
  logic signed [31:0] o_res, k_res;
  logic               o_sat, k_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v    <= 1'b0;
      skid_v <= 1'b0;
    end else if (!o_v || res.ready) begin
      if (skid_v) begin
        o_v    <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        o_v <= sg_v;
      end
    end else if (sg_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_v || res.ready) begin
      if (skid_v) begin
        o_res <= k_res;
        o_sat <= k_sat;
      end else begin
        o_res <= p_res;
        o_sat <= p_sat;
      end
    end else if (en) begin
      k_res <= p_res;
      k_sat <= p_sat;
    end
  end

  assign res.valid     = o_v;
  assign res.result    = o_res;
  assign res.saturated = o_sat;

endmodule

`default_nettype wire

FILE: rtl/nprox_isqrt.sv
// ----------------------------------------------------------------------------
// nprox_isqrt
// Pipelined floor square root of a 64-bit word, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module nprox_isqrt #(
  parameter type side_t = logic
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_v,
  input  wire logic [63:0] in_rad,
  input  wire side_t       in_side,
  output logic             out_v,
  output logic [31:0]      out_root,
  output side_t            out_side
);

  localparam int STAGES = 32;

  logic [63:0] rv [STAGES+1];
  logic [63:0] rr [STAGES+1];
  logic        sv [STAGES+1];
  side_t       sd [STAGES+1];

  always_comb begin
    rv[0] = in_rad;
    rr[0] = '0;
    sv[0] = in_v;
    sd[0] = in_side;
  end

  for (genvar j = 0; j < STAGES; j++) begin : g_it
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    logic        ge;

    assign trial = rr[j] + BIT;
    assign ge    = rv[j] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else if (en) begin
        sv[j+1] <= sv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[j+1] <= sd[j];
        if (ge) begin
          rv[j+1] <= rv[j] - trial;
          rr[j+1] <= (rr[j] >> 1) + BIT;
        end else begin
          rv[j+1] <= rv[j];
          rr[j+1] <= rr[j] >> 1;
        end
      end
    end
  end

  assign out_v    = sv[STAGES];
  assign out_root = rr[STAGES][31:0];
  assign out_side = sd[STAGES];

endmodule

`default_nettype wire

FILE: rtl/nprox_log2.sv
// ----------------------------------------------------------------------------
// nprox_log2
// Two-lane pipelined log2 with 28 fraction bits by repeated squaring.
// ----------------------------------------------------------------------------
`default_nettype none

module nprox_log2 #(
  parameter type side_t = logic
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_v,
  input  wire logic [33:0] in_a,
  input  wire logic [33:0] in_b,
  input  wire side_t       in_side,
  output logic             out_v,
  output logic [33:0]      out_la,
  output logic [33:0]      out_lb,
  output side_t            out_side
);

  localparam int ITER  = nprox_pkg::LN_FRAC;
  localparam int LANES = 2;

  // msb search stage
  logic        k_v;
  side_t       k_sd;
  logic [33:0] k_a [LANES];
  logic [5:0]  k_k [LANES];

  logic [31:0] m  [ITER+1][LANES];
  logic [33:0] r  [ITER+1][LANES];
  logic        sv [ITER+1];
  side_t       sd [ITER+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      k_v <= 1'b0;
    end else if (en) begin
      k_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_sd   <= in_side;
      k_a[0] <= in_a;
      k_a[1] <= in_b;
      k_k[0] <= nprox_pkg::msb_pos(in_a);
      k_k[1] <= nprox_pkg::msb_pos(in_b);
    end
  end

  // normalize mantissa into [2^31, 2^32)
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= k_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= k_sd;
      for (int l = 0; l < LANES; l++) begin
        if (k_k[l] >= 6'd31) begin
          m[0][l] <= 32'(k_a[l] >> (k_k[l] - 6'd31));
        end else begin
          m[0][l] <= 32'({30'd0, k_a[l]} << (6'd31 - k_k[l]));
        end
        r[0][l] <= {k_k[l], 28'd0};
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_it
    localparam logic [33:0] BITV = 34'd1 << (ITER - 1 - i);
    logic [63:0] sq [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        sq[l] = {32'd0, m[i][l]} * {32'd0, m[i][l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i+1] <= 1'b0;
      end else if (en) begin
        sv[i+1] <= sv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[i+1] <= sd[i];
        for (int l = 0; l < LANES; l++) begin
          if (sq[l][63]) begin
            m[i+1][l] <= sq[l][63:32];
            r[i+1][l] <= r[i][l] | BITV;
          end else begin
            m[i+1][l] <= sq[l][62:31];
            r[i+1][l] <= r[i][l];
          end
        end
      end
    end
  end

  assign out_v    = sv[ITER];
  assign out_la   = r[ITER][0];
  assign out_lb   = r[ITER][1];
  assign out_side = sd[ITER];

endmodule

`default_nettype wire
